FILE: sv/binary_lifting_lca_macros.svh
// Assertion macros used by the checker file of the LCA engine.
`ifndef BINARY_LIFTING_LCA_MACROS_SVH
`define BINARY_LIFTING_LCA_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define BLL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bll_pkg.sv
// Package of the LCA engine: sizes, command kinds, datapath operations, status struct.
`default_nettype none

package bll_pkg;

  localparam int MAX_NODES = 65536;
  localparam int LEVELS    = 16;

  localparam int FIELD_W = 16;
  localparam int DEPTH_W = 16;
  localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W  = NODE_W + LEVEL_W;
  localparam int CMP_W   = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC_LD,
    OP_ACC_Q,
    OP_LD_DEPTH,
    OP_LD_READ,
    OP_LD_STEP,
    OP_Q_SWAP,
    OP_LIFT_TEST,
    OP_LIFT_A,
    OP_LIFT_DEPTH,
    OP_P2_INIT,
    OP_P2_RD,
    OP_P2_CMP,
    OP_FIN_RD,
    OP_FIN,
    OP_RES_A
  } op_e;

  typedef struct packed {
    logic in_zero;   // loaded node maps to the sentinel
    logic lift;      // deeper node may climb 2^lvl levels
    logic a_eq_b;
    logic lvl_zero;
    logic lvl_last;
  } status_t;

  // Node numbers at or above MAX_NODES alias the sentinel.
  function automatic logic [NODE_W-1:0] node_map(input logic [FIELD_W-1:0] v);
    if (32'(v) >= 32'(MAX_NODES)) begin
      return '0;
    end
    return NODE_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: sv/bll_datapath.sv
// Datapath of the LCA engine: depth and ancestor memories, node and level registers.
`default_nettype none

module bll_datapath (
  input  wire logic                        clk_i,
  input  wire bll_pkg::op_e                op_i,
  input  wire logic [bll_pkg::FIELD_W-1:0] first_node_i,
  input  wire logic [bll_pkg::FIELD_W-1:0] second_node_i,
  output bll_pkg::status_t                 status_o,
  output logic      [bll_pkg::FIELD_W-1:0] ancestor_o
);
  import bll_pkg::*;

  localparam int ANC_ENTRIES = 2 ** ADDR_W;
  localparam int DEP_ENTRIES = 2 ** NODE_W;

  logic [FIELD_W-1:0] anc_mem [ANC_ENTRIES];
  logic [DEPTH_W-1:0] dep_mem [DEP_ENTRIES];

  logic [NODE_W-1:0]  a_q, a_d, b_q, b_d;
  logic [DEPTH_W-1:0] da_q, da_d, db_q, db_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  logic [FIELD_W-1:0] anc_q, anc_d;

  // Memory ports
  logic               anc_we;
  logic [ADDR_W-1:0]  anc_wa, anc_ra, anc_rb;
  logic [FIELD_W-1:0] anc_wd;
  logic               dep_we;
  logic [NODE_W-1:0]  dep_wa, dep_ra, dep_rb;
  logic [DEPTH_W-1:0] dep_wd;

  logic [FIELD_W-1:0] anc_ra_q, anc_rb_q;
  logic               anc_za_q, anc_zb_q;
  logic [DEPTH_W-1:0] dep_ra_q, dep_rb_q;
  logic               dep_za_q, dep_zb_q;

  // Sentinel node reads as zero everywhere; it is never written.
  logic [NODE_W-1:0]  pa, pb;
  logic [DEPTH_W-1:0] rda, rdb;
  logic [CMP_W-1:0]   lift_lhs, lift_rhs;
  logic [NODE_W-1:0]  in_first, in_second;
  logic [LEVEL_W-1:0] lvl_m1;

  assign pa  = anc_za_q ? '0 : node_map(anc_ra_q);
  assign pb  = anc_zb_q ? '0 : node_map(anc_rb_q);
  assign rda = dep_za_q ? '0 : dep_ra_q;
  assign rdb = dep_zb_q ? '0 : dep_rb_q;

  assign in_first  = node_map(first_node_i);
  assign in_second = node_map(second_node_i);
  assign lvl_m1    = lvl_q - LEVEL_W'(1);

  assign lift_lhs = CMP_W'(da_q);
  assign lift_rhs = CMP_W'(db_q) + (CMP_W'(1) << lvl_q);

  assign status_o.in_zero  = (in_first == '0);
  assign status_o.lift     = (lift_lhs >= lift_rhs);
  assign status_o.a_eq_b   = (a_q == b_q);
  assign status_o.lvl_zero = (lvl_q == '0);
  assign status_o.lvl_last = (lvl_q == LEVEL_W'(LEVELS - 1));

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    da_d   = da_q;
    db_d   = db_q;
    lvl_d  = lvl_q;
    anc_d  = anc_q;
    anc_we = 1'b0;
    anc_wa = {a_q, lvl_q};
    anc_wd = FIELD_W'(pa);
    anc_ra = {a_q, lvl_q};
    anc_rb = {b_q, lvl_q};
    dep_we = 1'b0;
    dep_wa = a_q;
    dep_wd = rdb + DEPTH_W'(1);
    dep_ra = a_q;
    dep_rb = b_q;
    case (op_i)
      OP_ACC_LD: begin
        a_d    = in_first;
        b_d    = in_second;
        lvl_d  = LEVEL_W'(1);
        anc_we = 1'b1;
        anc_wa = {in_first, LEVEL_W'(0)};
        anc_wd = FIELD_W'(in_second);
        dep_rb = in_second;
      end
      OP_ACC_Q: begin
        a_d    = in_first;
        b_d    = in_second;
        dep_ra = in_first;
        dep_rb = in_second;
      end
      OP_LD_DEPTH: begin
        dep_we = 1'b1;
        anc_ra = {b_q, lvl_m1};
      end
      OP_LD_READ: begin
        anc_ra = {b_q, lvl_m1};
      end
      OP_LD_STEP: begin
        anc_we = 1'b1;
        b_d    = pa;
        lvl_d  = lvl_q + LEVEL_W'(1);
      end
      OP_Q_SWAP: begin
        lvl_d = LEVEL_W'(LEVELS - 1);
        if (rda < rdb) begin
          a_d  = b_q;
          b_d  = a_q;
          da_d = rdb;
          db_d = rda;
        end else begin
          da_d = rda;
          db_d = rdb;
        end
      end
      OP_LIFT_TEST: begin
        if (!status_o.lift) begin
          lvl_d = lvl_m1;
        end
      end
      OP_LIFT_A: begin
        a_d    = pa;
        dep_ra = pa;
      end
      OP_LIFT_DEPTH: begin
        da_d  = rda;
        lvl_d = lvl_m1;
      end
      OP_P2_INIT: begin
        lvl_d = LEVEL_W'(LEVELS - 1);
      end
      OP_P2_RD: begin
        anc_ra = {a_q, lvl_q};
        anc_rb = {b_q, lvl_q};
      end
      OP_P2_CMP: begin
        if (pa != pb) begin
          a_d = pa;
          b_d = pb;
        end
        lvl_d = lvl_m1;
      end
      OP_FIN_RD: begin
        anc_ra = {a_q, LEVEL_W'(0)};
      end
      OP_FIN: begin
        anc_d = FIELD_W'(pa);
      end
      OP_RES_A: begin
        anc_d = FIELD_W'(a_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    da_q  <= da_d;
    db_q  <= db_d;
    lvl_q <= lvl_d;
    anc_q <= anc_d;
  end

  always_ff @(posedge clk_i) begin
    if (anc_we) begin
      anc_mem[anc_wa] <= anc_wd;
    end
    anc_ra_q <= anc_mem[anc_ra];
    anc_rb_q <= anc_mem[anc_rb];
    anc_za_q <= (anc_ra[ADDR_W-1:LEVEL_W] == '0);
    anc_zb_q <= (anc_rb[ADDR_W-1:LEVEL_W] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
    dep_ra_q <= dep_mem[dep_ra];
    dep_rb_q <= dep_mem[dep_rb];
    dep_za_q <= (dep_ra == '0);
    dep_zb_q <= (dep_rb == '0);
  end

  assign ancestor_o = anc_q;

endmodule

`default_nettype wire

FILE: sv/bll_ctrl.sv
// Controller of the LCA engine: sequences loads and queries over the datapath.
`default_nettype none

module bll_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic             kind_i,
  input  wire bll_pkg::status_t status_i,
  output bll_pkg::op_e          op_o,
  output logic                  busy,
  output logic                  done_o
);
  import bll_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LDDEP  = 4'd1;
  localparam logic [3:0] S_LDSTEP = 4'd2;
  localparam logic [3:0] S_LDRD   = 4'd3;
  localparam logic [3:0] S_QSWAP  = 4'd4;
  localparam logic [3:0] S_LIFT   = 4'd5;
  localparam logic [3:0] S_LIFTA  = 4'd6;
  localparam logic [3:0] S_LIFTD  = 4'd7;
  localparam logic [3:0] S_EQ     = 4'd8;
  localparam logic [3:0] S_P2RD   = 4'd9;
  localparam logic [3:0] S_P2CMP  = 4'd10;
  localparam logic [3:0] S_FINRD  = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (kind_i == KIND_QUERY) begin
            op_o    = OP_ACC_Q;
            state_d = S_QSWAP;
          end else if (!status_i.in_zero) begin
            op_o    = OP_ACC_LD;
            state_d = S_LDDEP;
          end
        end
      end
      S_LDDEP: begin
        op_o    = OP_LD_DEPTH;
        state_d = (LEVELS == 1) ? S_IDLE : S_LDSTEP;
      end
      S_LDSTEP: begin
        op_o    = OP_LD_STEP;
        state_d = status_i.lvl_last ? S_IDLE : S_LDRD;
      end
      S_LDRD: begin
        op_o    = OP_LD_READ;
        state_d = S_LDSTEP;
      end
      S_QSWAP: begin
        op_o    = OP_Q_SWAP;
        state_d = S_LIFT;
      end
      S_LIFT: begin
        op_o = OP_LIFT_TEST;
        if (status_i.lift) begin
          state_d = S_LIFTA;
        end else if (status_i.lvl_zero) begin
          state_d = S_EQ;
        end
      end
      S_LIFTA: begin
        op_o    = OP_LIFT_A;
        state_d = S_LIFTD;
      end
      S_LIFTD: begin
        op_o    = OP_LIFT_DEPTH;
        state_d = status_i.lvl_zero ? S_EQ : S_LIFT;
      end
      S_EQ: begin
        if (status_i.a_eq_b) begin
          op_o    = OP_RES_A;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_P2_INIT;
          state_d = S_P2RD;
        end
      end
      S_P2RD: begin
        op_o    = OP_P2_RD;
        state_d = S_P2CMP;
      end
      S_P2CMP: begin
        op_o    = OP_P2_CMP;
        state_d = status_i.lvl_zero ? S_FINRD : S_P2RD;
      end
      S_FINRD: begin
        op_o    = OP_FIN_RD;
        state_d = S_FIN;
      end
      S_FIN: begin
        op_o    = OP_FIN;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: sv/binary_lifting_lca.sv
// Top level of the binary lifting lowest common ancestor engine.
//
//   channel   dir  handshake        fields
//   command   in   start && !busy   kind_i, first_node_i, second_node_i
//   result    out  done_o strobe    ancestor_o
//
// A load keeps busy high after accept for one ancestor memory read and one write per
// level, each read waiting on the previous level's result.
// A query strobes its result after lifting the deeper node (a test per level and, where
// it may climb, an ancestor read, then its depth read) and a common climb that reads
// and compares both ancestors per level.
// A load of the sentinel node is consumed in its accept cycle.
// Reset clears only the controller; node 0 reads as zero without being stored.
// done_o pulses for one cycle as the engine returns to idle; it is never stalled.
`default_nettype none

module binary_lifting_lca (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        kind_i,
  input  wire logic [bll_pkg::FIELD_W-1:0] first_node_i,
  input  wire logic [bll_pkg::FIELD_W-1:0] second_node_i,
  output logic                             done_o,
  output logic      [bll_pkg::FIELD_W-1:0] ancestor_o
);
  import bll_pkg::*;

  op_e     op;
  status_t status;

  bll_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (kind_i),
    .status_i (status),
    .op_o     (op),
    .busy     (busy),
    .done_o   (done_o)
  );

  bll_datapath u_dp (
    .clk_i         (clk_i),
    .op_i          (op),
    .first_node_i  (first_node_i),
    .second_node_i (second_node_i),
    .status_o      (status),
    .ancestor_o    (ancestor_o)
  );

endmodule

`default_nettype wire

FILE: sv/bll_checker.sv
// Port-level checks of the LCA engine, bound to the top level.
`default_nettype none

`include "binary_lifting_lca_macros.svh"

module bll_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic kind_i,
  input wire logic done_o
);

  // A query transaction always occupies the engine.
  `BLL_ASSERT_NEXT(a_query_busy, start && !busy && kind_i, busy, "query accepted but engine idle")

  // A result comes only at the end of a busy period.
  `BLL_ASSERT_SAME(a_done_after_busy, done_o, $past(busy), "result without a transaction in flight")

  `BLL_ASSERT_SAME(a_done_idle, done_o, !busy, "result strobe while still busy")

  `BLL_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")

endmodule

bind binary_lifting_lca bll_checker u_bll_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .kind_i (kind_i),
  .done_o (done_o)
);

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the binary lifting LCA engine (directed + random traffic).
`timescale 1ns / 100ps

module tb;
  import bll_pkg::*;

  localparam int TOTAL_ITEMS = 1150;
  localparam int CALM_TAIL   = 150;   // no idling over the last stretch
  localparam int SETTLE_CYC  = 100;   // longer than the slowest query
  localparam int DRAIN_LIMIT = 5000;

  typedef logic [FIELD_W-1:0] node_t;
  typedef logic [LEVELS-1:0][FIELD_W-1:0] hop_row_t;

  class lca_scoreboard;
    logic [DEPTH_W-1:0] depth_of [int];
    hop_row_t hops [int];
    node_t lca_q [$];
    int mismatches;
    int loads;
    int queries;
    int deepest;

    function new();
      depth_of[0] = '0;
      hops[0] = '0;
    endfunction

    function node_t hop(node_t n, int lv);
      if (!hops.exists(n)) return '0;
      return hops[n][lv];
    endfunction

    function logic [DEPTH_W-1:0] depth_at(node_t n);
      if (!depth_of.exists(n)) return '0;
      return depth_of[n];
    endfunction

    // Parent depth is read before the node's own depth is rewritten,
    // which matters when a node is reloaded as its own parent.
    function void store_node(node_t n, node_t parent);
      logic [DEPTH_W-1:0] d;
      if (n == '0) return;
      d = depth_at(parent) + 1'b1;
      if (!hops.exists(n)) hops[n] = '0;
      hops[n][0] = parent;
      depth_of[n] = d;
      for (int lv = 1; lv < LEVELS; lv++) begin
        hops[n][lv] = hop(hop(n, lv - 1), lv - 1);
      end
      loads++;
      if (int'(d) > deepest) deepest = int'(d);
    endfunction

    function node_t lowest_common(node_t a_in, node_t b_in);
      node_t a;
      node_t b;
      node_t t;
      node_t pa;
      node_t pb;
      a = a_in;
      b = b_in;
      if (depth_at(a) < depth_at(b)) begin
        t = a;
        a = b;
        b = t;
      end
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
        if (32'(depth_at(a)) >= 32'(depth_at(b)) + (32'd1 << lv)) a = hop(a, lv);
      end
      if (a == b) return a;
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
        pa = hop(a, lv);
        pb = hop(b, lv);
        if (pa != pb) begin
          a = pa;
          b = pb;
        end
      end
      return hop(a, 0);
    endfunction

    function void note_transaction(kind_e k, node_t first, node_t second);
      if (k == KIND_LOAD) begin
        store_node(first, second);
      end else begin
        lca_q.push_back(lowest_common(first, second));
        queries++;
      end
    endfunction

    function void check_ancestor(node_t got);
      node_t want;
      if (lca_q.size() == 0) begin
        $error("ancestor: result %h arrived with no query outstanding", got);
        mismatches++;
      end else begin
        want = lca_q.pop_front();
        if (got !== want) begin
          $error("ancestor: expected %h, actual %h", want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return lca_q.size();
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start;
  logic  busy;
  logic  kind_i;
  node_t first_node_i;
  node_t second_node_i;
  logic  done_o;
  node_t ancestor_o;

  lca_scoreboard sb;
  node_t grown [$];          // nodes loaded so far, each once
  bit    is_grown [int];
  node_t last_loaded;
  int    sent;
  bit    idle_on;

  binary_lifting_lca dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .first_node_i (first_node_i),
    .second_node_i(second_node_i),
    .done_o       (done_o),
    .ancestor_o   (ancestor_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_ancestor(ancestor_o);
  end

  // start stays high between back-to-back transactions; it drops only for a gap or a drain.
  task automatic send(kind_e k, node_t first, node_t second);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= k;
    first_node_i  <= first;
    second_node_i <= second;
    do @(posedge clk_i); while (busy);
    sb.note_transaction(k, first, second);
    if (k == KIND_LOAD && first != '0) begin
      last_loaded = first;
      if (!is_grown.exists(first)) begin
        is_grown[first] = 1'b1;
        grown.push_back(first);
      end
    end
    // sentinel loads are ignored by the block and do not count
    if (k == KIND_QUERY || first != '0) sent++;
  endtask

  task automatic drain();
    if (sb.pending() != 0) begin
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
    end
  endtask

  function automatic node_t any_loaded();
    return grown[$urandom_range(0, grown.size() - 1)];
  endfunction

  function automatic node_t fresh_id();
    return node_t'($urandom_range(1, 2 ** FIELD_W - 1));
  endfunction

  initial begin
    #24ms;
    $display("binary_lifting_lca verification failed");
    $finish;
  end

  initial begin
    node_t a;
    node_t b;
    node_t base;
    node_t n;
    int    next_drain;
    int    wait_cycles;
    sb = new();
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind_i        <= KIND_LOAD;
    first_node_i  <= '0;
    second_node_i <= '0;
    sent    = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sentinel handling, field extremes, swap order, separate trees,
    // reload, self-parented node
    send(KIND_LOAD,  16'h0000, 16'h0000);
    send(KIND_QUERY, 16'h0000, 16'h0000);
    send(KIND_LOAD,  16'h0001, 16'h0000);
    send(KIND_LOAD,  16'hFFFF, 16'h0001);
    send(KIND_LOAD,  16'h8000, 16'hFFFF);
    send(KIND_LOAD,  16'h0002, 16'h0001);
    send(KIND_LOAD,  16'h5555, 16'h0002);
    send(KIND_LOAD,  16'hAAAA, 16'h5555);
    send(KIND_LOAD,  16'h7FFF, 16'h0000);
    send(KIND_QUERY, 16'hFFFF, 16'hFFFF);
    send(KIND_QUERY, 16'h8000, 16'hAAAA);
    send(KIND_QUERY, 16'hAAAA, 16'h8000);
    send(KIND_QUERY, 16'h0001, 16'h0000);
    send(KIND_QUERY, 16'h0000, 16'h8000);
    send(KIND_QUERY, 16'h7FFF, 16'hAAAA);
    send(KIND_QUERY, 16'h0002, 16'hAAAA);
    send(KIND_LOAD,  16'h0000, 16'hFFFF);
    send(KIND_LOAD,  16'h0002, 16'h7FFF);
    send(KIND_QUERY, 16'h5555, 16'h0002);
    send(KIND_LOAD,  16'h7FFF, 16'h7FFF);
    send(KIND_QUERY, 16'h7FFF, 16'h0001);
    send(KIND_QUERY, 16'h0000, 16'h7FFF);

    next_drain = 400;
    while (sent < TOTAL_ITEMS) begin
      idle_on = (sent < TOTAL_ITEMS - CALM_TAIL) && ($urandom_range(0, 1) == 1);
      if (sent >= next_drain) begin
        drain();
        next_drain += 400;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // grow a chain, often off the most recently loaded node
          base = ($urandom_range(0, 1) == 1) ? last_loaded : any_loaded();
          repeat ($urandom_range(8, 40)) begin
            n = fresh_id();
            send(KIND_LOAD, n, base);
            base = n;
          end
        end
        3, 4: begin
          repeat ($urandom_range(5, 15)) begin
            base = ($urandom_range(0, 3) == 0) ? node_t'(0) : any_loaded();
            send(KIND_LOAD, fresh_id(), base);
          end
        end
        5, 6, 7, 8: begin
          repeat ($urandom_range(5, 20)) begin
            a = any_loaded();
            case ($urandom_range(0, 9))
              0, 1, 2: b = any_loaded();
              3, 4, 5: begin
                b = a;
                repeat ($urandom_range(1, 6)) b = sb.hop(b, $urandom_range(0, 7));
              end
              6: b = a;
              7: b = '0;
              8: begin
                a = '0;
                b = any_loaded();
              end
              default: b = grown[grown.size() - 1 - $urandom_range(0, grown.size() > 20 ?
                                                                   20 : grown.size() - 1)];
            endcase
            if ($urandom_range(0, 1) == 1) send(KIND_QUERY, a, b);
            else send(KIND_QUERY, b, a);
          end
        end
        default: begin
          // odd traffic: sentinel loads, reloads, self-parented nodes
          repeat ($urandom_range(2, 6)) begin
            case ($urandom_range(0, 2))
              0: send(KIND_LOAD, 16'h0000, any_loaded());
              1: send(KIND_LOAD, any_loaded(), any_loaded());
              default: begin
                a = any_loaded();
                send(KIND_LOAD, a, a);
              end
            endcase
          end
        end
      endcase
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (sb.pending() != 0) begin
      $error("ancestor: %0d expected results never arrived", sb.pending());
      $display("binary_lifting_lca verification failed");
      $finish;
    end else begin
      repeat (SETTLE_CYC) @(posedge clk_i);
      $display("Covered %0d node loads and %0d LCA queries over %0d tree nodes;",
               sb.loads, sb.queries, grown.size());
      $display("deepest node reached depth %0d.", sb.deepest);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
        $display("binary_lifting_lca verification clean");
      end else begin
        $display("binary_lifting_lca verification failed");
      end
      $finish;
    end
  end

endmodule

FILE: sim.f
+incdir+sv
sv/bll_pkg.sv
sv/bll_datapath.sv
sv/bll_ctrl.sv
sv/binary_lifting_lca.sv
sv/bll_checker.sv
dv/tb.sv
